### design/bntms_pkg.sv
// ----------------------------------------------------------------------------
// bntms_pkg
// Shared types and constants for the binned top-N minimum-score selector.
// ----------------------------------------------------------------------------
package bntms_pkg;

    localparam int TOP_N      = 20;
    localparam int NUM_BINS   = 7;
    localparam int NUM_BOUNDS = 6;
    localparam int NUM_SLOTS  = NUM_BINS * TOP_N;

    localparam int SIZE_W  = 24;
    localparam int SCORE_W = 17;
    localparam int VOL_W   = 32;
    localparam int TAG_W   = 16;
    localparam int BIN_W   = 3;
    localparam int STAT_W  = 3;
    localparam int CIDX_W  = 3;
    localparam int FILL_W  = $clog2(TOP_N + 1);
    localparam int SLOT_W  = $clog2(NUM_SLOTS);

    localparam logic [STAT_W-1:0] ST_STORED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_REPLACED = 3'd1;
    localparam logic [STAT_W-1:0] ST_REJECTED = 3'd2;
    localparam logic [STAT_W-1:0] ST_IGNORED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_DUMP     = 3'd4;

    localparam logic REQ_OFFER = 1'b0;
    localparam logic REQ_DUMP  = 1'b1;

    localparam logic [SIZE_W-1:0] BOUND_RESET [NUM_BOUNDS] = '{
        24'd10, 24'd50, 24'd100, 24'd500, 24'd1000, 24'd5000
    };

    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [SCORE_W-1:0] score;
        logic [VOL_W-1:0]   volume;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    typedef struct packed {
        logic             is_dump;
        logic             zero;
        logic [BIN_W-1:0] bin;
        t_entry           data;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BIN_W-1:0]  bin;
        logic              valid;
        t_entry            data;
        logic              last;
    } t_result;

endpackage

### design/bntms_front.sv
// ----------------------------------------------------------------------------
// bntms_front
// Holds the bin bounds, classifies incoming requests and queues commands.
// ----------------------------------------------------------------------------
module bntms_front import bntms_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [SIZE_W-1:0]  i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic               i_req_type,
    input  logic [SIZE_W-1:0]  i_cluster_size,
    input  logic [SCORE_W-1:0] i_score,
    input  logic [VOL_W-1:0]   i_volume,
    input  logic [TAG_W-1:0]   i_cluster_tag,
    input  logic [BIN_W-1:0]   i_dump_bin,
    output logic               o_cmd_valid,
    output t_cmd               o_cmd,
    input  logic               i_cmd_pop
);

    logic [SIZE_W-1:0] r_bound [NUM_BOUNDS];
    t_cmd              r_q [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic [BIN_W-1:0]  pick;
    logic              found;
    t_cmd              cmd_in;
    logic              do_push;
    logic              do_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BOUNDS; b++) r_bound[b] <= BOUND_RESET[b];
        end else if (i_cfg_valid) begin
            for (int b = 0; b < NUM_BOUNDS; b++) begin
                if (i_cfg_index == CIDX_W'(b)) r_bound[b] <= i_cfg_data;
            end
        end
    end

    always_comb begin
        pick  = BIN_W'(NUM_BINS - 1);
        found = 1'b0;
        for (int b = 0; b < NUM_BOUNDS; b++) begin
            if (b + 1 < NUM_BINS && !found && i_cluster_size <= r_bound[b]) begin
                pick  = BIN_W'(b);
                found = 1'b1;
            end
        end
    end

    always_comb begin
        cmd_in.is_dump     = (i_req_type == REQ_DUMP);
        cmd_in.zero        = (i_cluster_size == '0);
        cmd_in.bin         = (i_req_type == REQ_DUMP) ? i_dump_bin : pick;
        cmd_in.data.size   = i_cluster_size;
        cmd_in.data.score  = i_score;
        cmd_in.data.volume = i_volume;
        cmd_in.data.tag    = i_cluster_tag;
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign do_push     = push && !full;
    assign do_pop      = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_q[r_wp] <= cmd_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

### design/bntms_out_queue.sv
// ----------------------------------------------------------------------------
// bntms_out_queue
// Two-entry result queue between the execution engine and the result port.
// ----------------------------------------------------------------------------
module bntms_out_queue import bntms_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_full,
    input  logic    pop,
    output logic    empty,
    output t_result o_res
);

    t_result    r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign empty   = (r_cnt == 2'd0);
    assign o_res   = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_q[r_wp] <= i_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

### design/bntms_back.sv
// ----------------------------------------------------------------------------
// bntms_back
// Executes queued commands against the slot memory: insert, replace the
// worst entry, or list a bin by repeated max-score scans.
// ----------------------------------------------------------------------------
module bntms_back import bntms_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;
    localparam logic [2:0] S_FETCH  = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    t_entry             r_mem [NUM_SLOTS];
    t_entry             r_rd_data;
    logic [2:0]         r_state;
    t_cmd               r_cmd;
    logic [FILL_W-1:0]  r_fill [NUM_BINS];
    logic [FILL_W-1:0]  r_n;
    logic [FILL_W-1:0]  r_rd_idx;
    logic               r_cmp_vld;
    logic [FILL_W-1:0]  r_cmp_idx;
    logic               r_have;
    logic [SCORE_W-1:0] r_best_score;
    logic [FILL_W-1:0]  r_best_idx;
    logic               r_first;
    logic [SCORE_W-1:0] r_last_score;
    logic [FILL_W-1:0]  r_last_idx;
    logic [FILL_W-1:0]  r_cnt;
    t_result            r_res;

    logic [FILL_W-1:0]  cur_fill;
    logic [SLOT_W-1:0]  base;
    logic [SLOT_W-1:0]  rd_addr;
    logic [SLOT_W-1:0]  wr_addr;
    logic               wr_en;
    logic               cand;
    logic               better;
    logic               bad_bin;

    always_comb begin
        cur_fill = '0;
        for (int b = 0; b < NUM_BINS; b++) begin
            if (r_cmd.bin == BIN_W'(b)) cur_fill = r_fill[b];
        end
    end

    assign base    = SLOT_W'(r_cmd.bin) * SLOT_W'(TOP_N);
    assign rd_addr = base + SLOT_W'((r_state == S_SCAN) ? r_rd_idx : r_best_idx);
    assign bad_bin = (r_cmd.bin >= BIN_W'(NUM_BINS));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = base + SLOT_W'(cur_fill);
        if (r_state == S_DECIDE && !r_cmd.is_dump && !r_cmd.zero && cur_fill < FILL_W'(TOP_N))
            wr_en = 1'b1;
        if (r_state == S_FINISH && !r_cmd.is_dump && r_cmd.data.score < r_best_score) begin
            wr_en   = 1'b1;
            wr_addr = base + SLOT_W'(r_best_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= r_cmd.data;
        r_rd_data <= r_mem[rd_addr];
    end

    assign cand = r_first || (r_rd_data.score < r_last_score) ||
                  (r_rd_data.score == r_last_score && r_cmp_idx > r_last_idx);
    assign better = cand && (!r_have || r_rd_data.score > r_best_score);

    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
            for (int b = 0; b < NUM_BINS; b++) r_fill[b] <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_res.valid <= 1'b0;
                    r_res.data  <= '0;
                    r_res.last  <= 1'b1;
                    r_res.bin   <= (!r_cmd.is_dump && r_cmd.zero) ? '0 : r_cmd.bin;
                    r_rd_idx    <= '0;
                    r_cmp_vld   <= 1'b0;
                    r_have      <= 1'b0;
                    r_first     <= 1'b1;
                    r_cnt       <= '0;
                    if (!r_cmd.is_dump) begin
                        if (r_cmd.zero) begin
                            r_res.status <= ST_IGNORED;
                            r_state      <= S_EMIT;
                        end else if (cur_fill < FILL_W'(TOP_N)) begin
                            for (int b = 0; b < NUM_BINS; b++) begin
                                if (r_cmd.bin == BIN_W'(b)) r_fill[b] <= cur_fill + 1'b1;
                            end
                            r_res.status <= ST_STORED;
                            r_state      <= S_EMIT;
                        end else begin
                            r_n     <= FILL_W'(TOP_N);
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_res.status <= ST_DUMP;
                        if (bad_bin || cur_fill == '0) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_n     <= cur_fill;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_cmp_vld && r_cmp_idx == r_n - 1'b1) begin
                        r_cmp_vld <= 1'b0;
                        r_state   <= S_FINISH;
                    end else if (r_rd_idx < r_n) begin
                        r_rd_idx  <= r_rd_idx + 1'b1;
                        r_cmp_vld <= 1'b1;
                        r_cmp_idx <= r_rd_idx;
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end
                    if (r_cmp_vld && better) begin
                        r_have       <= 1'b1;
                        r_best_score <= r_rd_data.score;
                        r_best_idx   <= r_cmp_idx;
                    end
                end
                S_FINISH: begin
                    if (!r_cmd.is_dump) begin
                        r_res.status <= (r_cmd.data.score < r_best_score) ?
                                        ST_REPLACED : ST_REJECTED;
                        r_state      <= S_EMIT;
                    end else begin
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_res.status <= ST_DUMP;
                    r_res.valid  <= 1'b1;
                    r_res.data   <= r_rd_data;
                    r_res.last   <= (r_cnt + 1'b1 == r_n);
                    r_last_score <= r_best_score;
                    r_last_idx   <= r_best_idx;
                    r_first      <= 1'b0;
                    r_cnt        <= r_cnt + 1'b1;
                    r_state      <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_res_ready) begin
                        if (r_res.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_rd_idx  <= '0;
                            r_cmp_vld <= 1'b0;
                            r_have    <= 1'b0;
                            r_state   <= S_SCAN;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### design/binned_top_n_min_selector_unit.sv
// ----------------------------------------------------------------------------
// binned_top_n_min_selector_unit
// Sorts offered clusters into size bins and keeps the lowest-score entries.
//
// Input channel: queue style, push/full. Each transaction is an offer
// (req_type 0) or a dump of one bin (req_type 1).
// Result channel: queue style, empty/pop. An offer yields one result with a
// status; a dump yields one result per stored entry in descending score
// order (lowest slot first on ties), last set on the final one.
// Config channel: cfg_valid/cfg_ready, always ready, writes bound registers.
// A free-slot offer is stored without a scan; an offer into a full bin first
// scans the bin's TOP_N slots for the highest score. A dump of n entries runs
// one max-score scan per entry; an empty bin yields one result, valid clear.
// Commands are executed one at a time; two commands queue up in front.
// Reset clears the fill counts and restores the default bounds; slot
// memory needs no clearing. When the receiver holds off pop, results fill
// a two-entry queue, then execution holds, then the input queue fills.
// ----------------------------------------------------------------------------
module binned_top_n_min_selector_unit import bntms_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [SIZE_W-1:0]  i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic               i_req_type,
    input  logic [SIZE_W-1:0]  i_cluster_size,
    input  logic [SCORE_W-1:0] i_score,
    input  logic [VOL_W-1:0]   i_volume,
    input  logic [TAG_W-1:0]   i_cluster_tag,
    input  logic [BIN_W-1:0]   i_dump_bin,
    output logic               empty,
    input  logic               pop,
    output logic [STAT_W-1:0]  o_status,
    output logic [BIN_W-1:0]   o_bin_index,
    output logic               o_entry_valid,
    output logic [SIZE_W-1:0]  o_out_size,
    output logic [SCORE_W-1:0] o_out_score,
    output logic [VOL_W-1:0]   o_out_volume,
    output logic [TAG_W-1:0]   o_out_tag,
    output logic               o_last
);

    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_pop;
    logic    res_valid;
    t_result res;
    logic    oq_full;
    t_result oq_res;

    bntms_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_req_type     (i_req_type),
        .i_cluster_size (i_cluster_size),
        .i_score        (i_score),
        .i_volume       (i_volume),
        .i_cluster_tag  (i_cluster_tag),
        .i_dump_bin     (i_dump_bin),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    bntms_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (!oq_full)
    );

    bntms_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_full  (oq_full),
        .pop     (pop),
        .empty   (empty),
        .o_res   (oq_res)
    );

    assign o_status      = oq_res.status;
    assign o_bin_index   = oq_res.bin;
    assign o_entry_valid = oq_res.valid;
    assign o_out_size    = oq_res.data.size;
    assign o_out_score   = oq_res.data.score;
    assign o_out_volume  = oq_res.data.volume;
    assign o_out_tag     = oq_res.data.tag;
    assign o_last        = oq_res.last;

endmodule
